// File: hdl/tplru_pkg.sv
// shared types and constants of the tree pseudo-lru victim select unit
package tplru_pkg;

    // fixed field widths of the request and response
    localparam int unsigned SET_INDEX_W = 6;
    localparam int unsigned WAY_W       = 3;
    localparam int unsigned MASK_W      = 8;
    localparam int unsigned SET_RANGE   = 1 << SET_INDEX_W;

    // request operation codes
    typedef enum logic {
        OP_TOUCH  = 1'b0,
        OP_VICTIM = 1'b1
    } t_opcode;

    // request payload
    typedef struct packed {
        t_opcode                  opcode;
        logic [SET_INDEX_W-1:0]   set_index;
        logic [WAY_W-1:0]         way;
        logic [MASK_W-1:0]        reserved_mask;
    } t_req;

    // response payload
    typedef struct packed {
        logic                     victim_valid;
        logic [WAY_W-1:0]         victim_way;
    } t_rsp;

    // controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_SEARCH
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic accept;     // capture the incoming request, read its set
        logic src_ram;    // work on the set state just read from memory
        logic step;       // keep the touched tree and try another descent
        logic finish;     // write the set state back and load the response
        logic clr_step;   // zero one set of the state memory
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic op_victim;  // captured request asks for a victim
        logic full;       // set has handed out all its ways
        logic reserved;   // way reached by the descent may not be taken
        logic last_iter;  // this descent is the final permitted one
        logic out_free;   // response register can take a new response
        logic clr_last;   // clearing pass is at its final set
    } t_dp_status;

endpackage

// File: hdl/tplru_ram.sv
// generic single-port-write, single-port-read ram with registered read
module tplru_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/tplru_ctrl.sv
// controller state machine of the tree pseudo-lru victim select unit
module tplru_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_req_valid,
    output logic                   o_req_ready,
    output tplru_pkg::t_dp_cmd     o_cmd,
    input  tplru_pkg::t_dp_status  i_status
);

    import tplru_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   done;

    // a request completes on a touch, a fill, a free way or the final descent
    assign done = !i_status.op_victim || !i_status.full || !i_status.reserved
                  || i_status.last_iter;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD, ST_SEARCH: begin
                if (!done) begin
                    n_state = ST_SEARCH;
                end else if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // commands
    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            ST_IDLE: begin
                o_req_ready  = 1'b1;
                o_cmd.accept = i_req_valid;
            end
            ST_LOAD, ST_SEARCH: begin
                o_cmd.src_ram = (r_state == ST_LOAD);
                o_cmd.step    = !done;
                o_cmd.finish  = done && i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // no request is taken during the clearing pass
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_cmd.accept)
        else $error("request accepted during clearing pass");

    // a finished request always returns to idle
    a_finish_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> (r_state == ST_IDLE))
        else $error("controller did not return to idle after finish");

    // a retry never coincides with a write-back
    a_step_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |-> !(o_cmd.finish || o_cmd.clr_step))
        else $error("retry and write-back issued together");

endmodule

// File: hdl/tplru_dp.sv
// datapath of the tree pseudo-lru victim select unit: set memory, tree walks, response
module tplru_dp #(
    parameter int unsigned SET_COUNT = 64,
    parameter int unsigned WAY_COUNT = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tplru_pkg::t_req        i_req,
    input  tplru_pkg::t_dp_cmd     i_cmd,
    output tplru_pkg::t_dp_status  o_status,
    output logic                   o_rsp_valid,
    input  logic                   i_rsp_ready,
    output tplru_pkg::t_rsp        o_rsp
);

    import tplru_pkg::*;

    localparam int unsigned TREE_D    = $clog2(WAY_COUNT);
    localparam int unsigned WAYS_P2   = 1 << TREE_D;
    localparam int unsigned TREE_W    = WAYS_P2 - 1;
    localparam int unsigned NODE_W    = TREE_D + 1;
    localparam int unsigned CNT_W     = $clog2(WAY_COUNT + 1);
    localparam int unsigned RAM_W     = TREE_W + CNT_W;
    localparam int unsigned SETS_USED = (SET_COUNT < SET_RANGE) ? SET_COUNT : SET_RANGE;
    localparam int unsigned SET_W     = (SETS_USED > 1) ? $clog2(SETS_USED) : 1;

    // captured request
    t_opcode           r_op;
    logic [SET_W-1:0]  r_set;
    logic [WAY_W-1:0]  r_way;
    logic [MASK_W-1:0] r_mask;

    // working copy of the set state during retries
    logic [TREE_W-1:0] r_tree;
    logic [CNT_W-1:0]  r_cnt;
    logic [TREE_D-1:0] r_iter;

    logic [SET_W-1:0]  r_clr;
    logic              r_out_valid;
    t_rsp              r_out;

    logic [SET_W-1:0]  set_map [SET_RANGE];
    logic [SET_W-1:0]  in_set;
    logic [SET_W-1:0]  rd_addr;
    logic [SET_W-1:0]  wr_addr;
    logic [RAM_W-1:0]  wr_data;
    logic              wr_en;
    logic [RAM_W-1:0]  rd_data;

    logic [TREE_W-1:0] src_tree;
    logic [CNT_W-1:0]  src_cnt;
    logic [TREE_D-1:0] cur_iter;
    logic              full;
    logic [TREE_D-1:0] desc_way;
    logic [TREE_D-1:0] sel_way;
    logic [TREE_W-1:0] new_tree;
    logic [CNT_W-1:0]  new_cnt;
    logic [WAYS_P2-1:0] rsv_vec;
    logic              reserved;
    logic              out_free;
    t_rsp              rsp_next;

    // set index folded into the implemented sets
    for (genvar g = 0; g < SET_RANGE; g++) begin : g_set_map
        localparam int unsigned SET_FOLD = g % SET_COUNT;
        assign set_map[g] = SET_W'(SET_FOLD);
    end

    assign in_set = set_map[i_req.set_index];

    // reserved ways, ways past the implemented count included
    for (genvar k = 0; k < WAYS_P2; k++) begin : g_rsv
        if (k >= WAY_COUNT) begin : g_absent
            assign rsv_vec[k] = 1'b1;
        end else if (k < MASK_W) begin : g_masked
            assign rsv_vec[k] = r_mask[k];
        end else begin : g_open
            assign rsv_vec[k] = 1'b0;
        end
    end

    // set state memory: tree bits above the fill count
    assign rd_addr = i_cmd.accept ? in_set : r_set;
    assign wr_en   = i_cmd.finish || i_cmd.clr_step;
    assign wr_addr = i_cmd.clr_step ? r_clr : r_set;
    assign wr_data = i_cmd.clr_step ? '0 : {new_tree, new_cnt};

    tplru_ram #(
        .WIDTH (RAM_W),
        .DEPTH (SETS_USED)
    ) u_state_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // source of the set state for this pass
    assign src_tree = i_cmd.src_ram ? rd_data[RAM_W-1:CNT_W] : r_tree;
    assign src_cnt  = i_cmd.src_ram ? rd_data[CNT_W-1:0] : r_cnt;
    assign cur_iter = i_cmd.src_ram ? '0 : r_iter;
    assign full     = (src_cnt >= CNT_W'(WAY_COUNT));

    // descent: a clear node goes left, a set node goes right
    always_comb begin
        logic [NODE_W-1:0] d_node;
        d_node = NODE_W'(1);
        for (int l = 0; l < TREE_D; l++) begin
            d_node = {d_node[TREE_D-1:0], src_tree[TREE_D'(d_node - 1'b1)]};
        end
        desc_way = d_node[TREE_D-1:0];
    end

    // way to mark as recently used
    always_comb begin
        if (r_op == OP_TOUCH) begin
            sel_way = TREE_D'(r_way);
        end else if (!full) begin
            sel_way = TREE_D'(src_cnt);
        end else begin
            sel_way = desc_way;
        end
    end

    // touch: nodes on the path point away from the way
    always_comb begin
        logic [NODE_W-1:0] t_node;
        t_node   = NODE_W'(1);
        new_tree = src_tree;
        for (int l = TREE_D; l > 0; l--) begin
            new_tree[TREE_D'(t_node - 1'b1)] = ~sel_way[l-1];
            t_node = {t_node[TREE_D-1:0], sel_way[l-1]};
        end
    end

    assign new_cnt  = (r_op == OP_VICTIM && !full) ? src_cnt + 1'b1 : src_cnt;
    assign reserved = rsv_vec[desc_way];
    assign out_free = !r_out_valid || i_rsp_ready;

    // response for a completed request
    always_comb begin
        rsp_next.victim_valid = (r_op == OP_VICTIM) && (!full || !reserved);
        rsp_next.victim_way   = rsp_next.victim_valid ? WAY_W'(sel_way) : '0;
    end

    // status towards the controller
    always_comb begin
        o_status.op_victim = (r_op == OP_VICTIM);
        o_status.full      = full;
        o_status.reserved  = reserved;
        o_status.last_iter = (cur_iter == TREE_D'(WAY_COUNT - 1));
        o_status.out_free  = out_free;
        o_status.clr_last  = (r_clr == SET_W'(SETS_USED - 1));
    end

    // request capture and retry state
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= i_req.opcode;
            r_set  <= in_set;
            r_way  <= i_req.way;
            r_mask <= i_req.reserved_mask;
        end
        if (i_cmd.step) begin
            r_tree <= new_tree;
            r_cnt  <= src_cnt;
            r_iter <= cur_iter + 1'b1;
        end
        if (i_cmd.finish) begin
            r_out <= rsp_next;
        end
    end

    // clearing pass address and response valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    // a response is loaded only into a free response register
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> out_free)
        else $error("response overwritten before it was taken");

    // no victim means way zero
    a_way_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.victim_valid) |-> (r_out.victim_way == '0))
        else $error("victim way set without a victim");

    // a waiting response holds until it is taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_rsp_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("response changed before it was taken");

endmodule

// File: hdl/tree_plru_victim_select_unit.sv
// top level of the tree pseudo-lru victim select unit
//
//  channel   direction  handshake                    payload
//  request   in         i_req_valid / o_req_ready    i_req  (opcode, set, way, reserved mask)
//  response  out        o_rsp_valid / i_rsp_ready    o_rsp  (victim valid, victim way)
//
// a touch, a victim on a set still filling, or a victim found on the first
// descent reads the set state from the state memory, then walks the tree,
// writes the set back and loads the response register. each descent that
// lands on a reserved way is followed by another, up to WAY_COUNT in all.
// after reset a clearing pass zeroes min(SET_COUNT, 64) sets, one per cycle,
// before the first request is taken.
// a new request is taken while a response waits; a stalled response holds
// the unit in its final step until the response register frees up.
module tree_plru_victim_select_unit #(
    parameter int unsigned SET_COUNT = 64,
    parameter int unsigned WAY_COUNT = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  tplru_pkg::t_req   i_req,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output tplru_pkg::t_rsp   o_rsp
);

    import tplru_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // sequencing
    tplru_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // set state and tree walks
    tplru_dp #(
        .SET_COUNT (SET_COUNT),
        .WAY_COUNT (WAY_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

endmodule

// File: verif/tree_plru_victim_select_unit_tb.sv
// testbench of the tree pseudo-lru victim select unit: directed table, then random requests
`timescale 1ns / 100ps

module tree_plru_victim_select_unit_tb;
    import tplru_pkg::*;

    localparam int unsigned SETS           = SET_RANGE;
    localparam int unsigned WAYS           = 1 << WAY_W;
    localparam int unsigned RANDOM_ITEMS   = 1080;
    localparam int unsigned CALM_ITEMS     = 150;
    localparam int unsigned DRAIN_CYCLES   = 2 * WAYS + 4;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned PRINT_LIMIT    = 40;

    // one row of the directed table; want is used only where typed is set
    typedef struct packed {
        t_req req;
        logic typed;
        t_rsp want;
    } t_plru_row;

    logic       i_clk     = 1'b0;
    logic       rst_n     = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    t_req       req       = '0;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    t_rsp       rsp;

    // typed expectation travelling with the request on the wire
    logic       row_typed = 1'b0;
    t_rsp       row_rsp   = '0;

    // predictor state, one entry per set
    logic [WAYS-2:0] node_bits [SETS];
    logic [WAY_W:0]  fill_cnt  [SETS];

    t_rsp        victim_q [$];
    t_plru_row   directed_rows [$];
    int unsigned mismatch_cnt = 0;
    int unsigned idle_cycles  = 0;
    bit          calm         = 1'b0;

    tree_plru_victim_select_unit #(
        .SET_COUNT (SETS),
        .WAY_COUNT (WAYS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // reset state of the predictor
    initial begin
        for (int s = 0; s < SETS; s++) begin
            node_bits[s] = '0;
            fill_cnt[s]  = '0;
        end
    end

    // mark the path to a way: left writes 1, right writes 0
    function automatic void mark_path(logic [SET_INDEX_W-1:0] s, logic [WAY_W-1:0] w);
        int unsigned node = 1;
        for (int l = WAY_W; l > 0; l--) begin
            if (w[l-1] == 1'b0) begin
                node_bits[s][node-1] = 1'b1;
                node = 2 * node;
            end else begin
                node_bits[s][node-1] = 1'b0;
                node = 2 * node + 1;
            end
        end
    endfunction

    // victim choice for one request, updating the set state as the unit does
    function automatic t_rsp plru_predict(t_req r);
        t_rsp                   result;
        logic [WAY_W-1:0]       cand;
        logic [SET_INDEX_W-1:0] s;
        int unsigned            node;
        int unsigned            tries;
        result = '0;
        s      = r.set_index;
        if (r.opcode == OP_TOUCH) begin
            mark_path(s, r.way);
            return result;
        end
        // set still filling: hand out the next way, mask not consulted
        if (fill_cnt[s] < WAYS) begin
            result.victim_valid = 1'b1;
            result.victim_way   = fill_cnt[s][WAY_W-1:0];
            mark_path(s, fill_cnt[s][WAY_W-1:0]);
            fill_cnt[s] = fill_cnt[s] + 1'b1;
            return result;
        end
        // full set: descend and touch until a free way or out of tries
        tries = 0;
        do begin
            node = 1;
            for (int l = 0; l < WAY_W; l++)
                node = 2 * node + node_bits[s][node-1];
            cand = WAY_W'(node - WAYS);
            mark_path(s, cand);
            tries++;
        end while (r.reserved_mask[cand] && tries < WAYS);
        if (!r.reserved_mask[cand]) begin
            result.victim_valid = 1'b1;
            result.victim_way   = cand;
        end
        return result;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatch_cnt++;
        if (mismatch_cnt <= PRINT_LIMIT)
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    function automatic void add_row(t_opcode op, int s, int w, int mask, bit typed,
                                    bit v, int vw);
        t_plru_row row;
        row.req.opcode        = op;
        row.req.set_index     = SET_INDEX_W'(s);
        row.req.way           = WAY_W'(w);
        row.req.reserved_mask = MASK_W'(mask);
        row.typed             = typed;
        row.want.victim_valid = v;
        row.want.victim_way   = WAY_W'(vw);
        directed_rows.push_back(row);
    endfunction

    // present one request, with an occasional gap before it
    task automatic send_request(t_req r, bit typed, t_rsp want);
        if (!calm && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        row_typed <= typed;
        row_rsp   <= want;
        do @(posedge i_clk); while (!req_ready);
    endtask

    // predict on each accepted request, check each accepted response
    always @(posedge i_clk) begin : monitor
        t_rsp predicted;
        t_rsp want;
        if (rst_n) begin
            if (req_valid && req_ready) begin
                predicted = plru_predict(req);
                victim_q.push_back(row_typed ? row_rsp : predicted);
            end
            if (rsp_valid && rsp_ready) begin
                if (victim_q.size() == 0) begin
                    report_mismatch("response with none outstanding", int'(rsp), 0);
                end else begin
                    want = victim_q.pop_front();
                    if (rsp.victim_valid !== want.victim_valid)
                        report_mismatch("victim_valid", int'(rsp.victim_valid),
                                        int'(want.victim_valid));
                    if (rsp.victim_way !== want.victim_way)
                        report_mismatch("victim_way", int'(rsp.victim_way),
                                        int'(want.victim_way));
                end
            end
        end
    end

    // stop the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // response side: ready high for a while, with an occasional stall burst before it
    initial begin
        @(posedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // request side
    initial begin : stimulus
        t_req        r;
        logic [5:0]  pool [4];
        int unsigned pick;

        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;

        // fresh set: fill count handed out in order, mask ignored
        add_row(OP_VICTIM, 0, 0, 8'h00, 1, 1, 0);
        for (int w = 1; w < WAYS; w++)
            add_row(OP_VICTIM, 0, 7 - w, 8'hFF, 1, 1, w);
        // full set with every way reserved
        add_row(OP_VICTIM, 0, 0, 8'hFF, 1, 0, 0);
        // touches give an empty response
        add_row(OP_TOUCH, 0, 7, 8'hFF, 1, 0, 0);
        add_row(OP_TOUCH, 63, 0, 8'h00, 1, 0, 0);
        add_row(OP_VICTIM, 0, 0, 8'h00, 0, 0, 0);
        add_row(OP_VICTIM, 0, 5, 8'h7F, 0, 0, 0);
        add_row(OP_VICTIM, 0, 2, 8'hFE, 0, 0, 0);
        add_row(OP_TOUCH, 0, 0, 8'h00, 1, 0, 0);
        add_row(OP_VICTIM, 0, 0, 8'h01, 0, 0, 0);
        add_row(OP_VICTIM, 0, 7, 8'hAA, 0, 0, 0);
        // top set still empty: way 0 even with every way reserved
        add_row(OP_VICTIM, 63, 7, 8'hFF, 1, 1, 0);
        add_row(OP_TOUCH, 32, 5, 8'h55, 1, 0, 0);
        add_row(OP_VICTIM, 0, 3, 8'h80, 0, 0, 0);
        add_row(OP_VICTIM, 0, 4, 8'hFF, 1, 0, 0);

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed,
                         directed_rows[i].want);

        // a few hot sets so that most victim requests hit full sets
        foreach (pool[i])
            pool[i] = SET_INDEX_W'($urandom_range(0, SETS - 1));

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k >= RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            r.opcode    = t_opcode'($urandom_range(0, 1));
            r.set_index = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 3)]
                                                     : SET_INDEX_W'($urandom_range(0, SETS - 1));
            r.way       = WAY_W'($urandom_range(0, WAYS - 1));
            pick        = $urandom_range(0, 7);
            case (pick)
                0, 1: r.reserved_mask = 8'h00;
                2: r.reserved_mask = 8'hFF;
                3, 4: r.reserved_mask = ~(8'h01 << $urandom_range(0, WAYS - 1));
                default: r.reserved_mask = MASK_W'($urandom_range(0, 255));
            endcase
            send_request(r, 1'b0, '0);
        end
        req_valid <= 1'b0;

        // drain outstanding responses, then allow for stragglers
        while (victim_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
